// ===== rtl/core/nns_pkg.sv =====
package nns_pkg;

    localparam int COORD_W   = 12;
    localparam int SIDE_W    = 13;
    localparam int CHAN_W    = 3;
    localparam int OFF_W     = 26;
    localparam int PROD_W    = COORD_W + SIDE_W;
    localparam int DIV_STEPS = COORD_W;
    localparam int MAX_SIDE  = 4096;
    localparam int MAX_CHAN  = 4;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_DST_WIDTH   = 3'd2,
        CFG_DST_HEIGHT  = 3'd3,
        CFG_PIXEL_BYTES = 3'd4
    } t_cfg_idx;

    // one axis of the division in flight
    typedef struct packed {
        logic               clamp;
        logic [SIDE_W-1:0]  rem;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] quo;
    } t_axis;

    // word handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  oor;
        t_axis ax_x;
        t_axis ax_y;
    } t_cell_word;

    // size register as used: zero reads as one, oversize as the maximum
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // channel count as used: zero reads as one, above four as four
    function automatic logic [CHAN_W-1:0] eff_chan(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] r;
        if (v == '0) begin
            r = CHAN_W'(1);
        end else if (v > CHAN_W'(MAX_CHAN)) begin
            r = CHAN_W'(MAX_CHAN);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/nns_front.sv =====
module nns_front
    import nns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [COORD_W-1:0] i_dst_col,
    input  logic [COORD_W-1:0] i_dst_row,
    input  logic [SIDE_W-1:0]  i_sw,
    input  logic [SIDE_W-1:0]  i_sh,
    input  logic [SIDE_W-1:0]  i_dw,
    input  logic [SIDE_W-1:0]  i_dh,
    output t_cell_word         o_word
);

    logic              r_valid;
    logic              r_oor;
    logic              r_clamp_x;
    logic              r_clamp_y;
    logic [PROD_W-1:0] r_num_x;
    logic [PROD_W-1:0] r_num_y;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    // dividends and range flags; a coordinate at or past the destination
    // size always maps past the last source pixel, so it is clamped
    always_ff @(posedge i_clk) begin
        r_num_x   <= PROD_W'(i_dst_col) * PROD_W'(i_sw);
        r_num_y   <= PROD_W'(i_dst_row) * PROD_W'(i_sh);
        r_clamp_x <= SIDE_W'(i_dst_col) >= i_dw;
        r_clamp_y <= SIDE_W'(i_dst_row) >= i_dh;
        r_oor     <= (SIDE_W'(i_dst_col) >= i_dw) || (SIDE_W'(i_dst_row) >= i_dh);
    end

    // the upper dividend bits seed the partial remainder
    always_comb begin
        o_word.valid      = r_valid;
        o_word.oor        = r_oor;
        o_word.ax_x.clamp = r_clamp_x;
        o_word.ax_x.rem   = SIDE_W'(r_num_x[PROD_W-2:COORD_W]);
        o_word.ax_x.low   = r_num_x[COORD_W-1:0];
        o_word.ax_x.quo   = '0;
        o_word.ax_y.clamp = r_clamp_y;
        o_word.ax_y.rem   = SIDE_W'(r_num_y[PROD_W-2:COORD_W]);
        o_word.ax_y.low   = r_num_y[COORD_W-1:0];
        o_word.ax_y.quo   = '0;
    end

endmodule

// ===== rtl/core/nns_cell.sv =====
module nns_cell
    import nns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_word        i_word,
    input  logic [SIDE_W-1:0] i_div_x,
    input  logic [SIDE_W-1:0] i_div_y,
    output t_cell_word        o_word
);

    t_cell_word r_word;
    t_cell_word n_word;

    // one restoring division step: shift in the next dividend bit
    function automatic t_axis div_step(input t_axis a, input logic [SIDE_W-1:0] d);
        t_axis             r;
        logic [SIDE_W:0]   t;
        logic              ge;
        t  = {a.rem, a.low[COORD_W-1]};
        ge = t >= {1'b0, d};
        r.clamp = a.clamp;
        r.low   = {a.low[COORD_W-2:0], 1'b0};
        r.quo   = {a.quo[COORD_W-2:0], ge};
        r.rem   = ge ? SIDE_W'(t - {1'b0, d}) : SIDE_W'(t);
        return r;
    endfunction

    // step both axes
    always_comb begin
        n_word.valid = i_word.valid;
        n_word.oor   = i_word.oor;
        n_word.ax_x  = div_step(i_word.ax_x, i_div_x);
        n_word.ax_y  = div_step(i_word.ax_y, i_div_y);
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_word.oor  <= n_word.oor;
        r_word.ax_x <= n_word.ax_x;
        r_word.ax_y <= n_word.ax_y;
    end

    assign o_word = r_word;

endmodule

// ===== rtl/core/nns_back.sv =====
module nns_back
    import nns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_word         i_word,
    input  logic [SIDE_W-1:0]  i_sw,
    input  logic [SIDE_W-1:0]  i_sh,
    input  logic [CHAN_W-1:0]  i_ch,
    output logic               o_valid,
    output logic [COORD_W-1:0] o_src_col,
    output logic [COORD_W-1:0] o_src_row,
    output logic [OFF_W-1:0]   o_src_offset,
    output logic               o_out_of_range
);

    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;

    logic               r_p_valid;
    logic               r_p_oor;
    logic [COORD_W-1:0] r_p_col;
    logic [COORD_W-1:0] r_p_row;
    logic [PROD_W-1:0]  r_p_prod;

    logic [PROD_W-1:0]  sum;

    logic               r_valid;
    logic               r_oor;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [OFF_W-1:0]   r_off;

    // clamp to the last source column and row
    assign col = i_word.ax_x.clamp ? COORD_W'(i_sw - SIDE_W'(1)) : i_word.ax_x.quo;
    assign row = i_word.ax_y.clamp ? COORD_W'(i_sh - SIDE_W'(1)) : i_word.ax_y.quo;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_p_valid <= i_word.valid;
            r_valid   <= r_p_valid;
        end
    end

    // row start in pixels
    always_ff @(posedge i_clk) begin
        r_p_oor  <= i_word.oor;
        r_p_col  <= col;
        r_p_row  <= row;
        r_p_prod <= PROD_W'(row) * PROD_W'(i_sw);
    end

    assign sum = r_p_prod + PROD_W'(r_p_col);

    // byte offset, scaled by the small channel count
    always_ff @(posedge i_clk) begin
        r_oor <= r_p_oor;
        r_col <= r_p_col;
        r_row <= r_p_row;
        r_off <= OFF_W'(sum) * OFF_W'(i_ch);
    end

    assign o_valid        = r_valid;
    assign o_out_of_range = r_oor;
    assign o_src_col      = r_col;
    assign o_src_row      = r_row;
    assign o_src_offset   = r_off;

endmodule

// ===== rtl/core/nearest_neighbour_scale_address.sv =====
// nearest-neighbor scaling address generator
//
// input: a destination coordinate on i_dst_col / i_dst_row is taken at each
// rising edge with start high and busy low. busy is always low, so a new
// coordinate may be given in every cycle: one word per clock, sustained.
//
// output: o_valid is high for exactly one cycle with o_src_col, o_src_row,
// o_src_offset and o_out_of_range. results come back in order, through
// fifteen register stages: one behind the dividend multipliers, twelve for
// the chain of division cells (one quotient bit per cell), two for the
// offset multiply and add. the receiver cannot stall.
//
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. the user must make writes only while no coordinate
// is in flight; the block does not enforce it. unknown indexes are ignored.
//
// reset (synchronous, active low) sets all sizes and the channel count to
// one and drops every word in flight.
module nearest_neighbour_scale_address
    import nns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   i_dst_col,
    input  logic [COORD_W-1:0]   i_dst_row,
    output logic                 o_valid,
    output logic [COORD_W-1:0]   o_src_col,
    output logic [COORD_W-1:0]   o_src_row,
    output logic [OFF_W-1:0]     o_src_offset,
    output logic                 o_out_of_range,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIDE_W-1:0]    i_cfg_data
);

    logic [SIDE_W-1:0] r_src_width;
    logic [SIDE_W-1:0] r_src_height;
    logic [SIDE_W-1:0] r_dst_width;
    logic [SIDE_W-1:0] r_dst_height;
    logic [CHAN_W-1:0] r_pixel_bytes;

    logic [SIDE_W-1:0] sw;
    logic [SIDE_W-1:0] sh;
    logic [SIDE_W-1:0] dw;
    logic [SIDE_W-1:0] dh;
    logic [CHAN_W-1:0] ch;

    t_cell_word chain [0:DIV_STEPS];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= SIDE_W'(1);
            r_src_height  <= SIDE_W'(1);
            r_dst_width   <= SIDE_W'(1);
            r_dst_height  <= SIDE_W'(1);
            r_pixel_bytes <= CHAN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:   r_src_width   <= i_cfg_data;
                CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_data;
                CFG_DST_WIDTH:   r_dst_width   <= i_cfg_data;
                CFG_DST_HEIGHT:  r_dst_height  <= i_cfg_data;
                CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes as used
    assign sw = eff_side(r_src_width);
    assign sh = eff_side(r_src_height);
    assign dw = eff_side(r_dst_width);
    assign dh = eff_side(r_dst_height);
    assign ch = eff_chan(r_pixel_bytes);

    nns_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (start && !busy),
        .i_dst_col (i_dst_col),
        .i_dst_row (i_dst_row),
        .i_sw      (sw),
        .i_sh      (sh),
        .i_dw      (dw),
        .i_dh      (dh),
        .o_word    (chain[0])
    );

    // division chain, one quotient bit per cell
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        nns_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (chain[g]),
            .i_div_x (dw),
            .i_div_y (dh),
            .o_word  (chain[g+1])
        );
    end

    nns_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (chain[DIV_STEPS]),
        .i_sw           (sw),
        .i_sh           (sh),
        .i_ch           (ch),
        .o_valid        (o_valid),
        .o_src_col      (o_src_col),
        .o_src_row      (o_src_row),
        .o_src_offset   (o_src_offset),
        .o_out_of_range (o_out_of_range)
    );

endmodule
